// File: rtl/hpt_pkg.sv
// Shared constants for the homogeneous point transform unit.
// No dependencies.
package hpt_pkg;

    localparam int COORD_W  = 32;
    localparam int FRAC_W   = 16;
    localparam int NUM_REGS = 8;
    localparam int CFG_W    = 64;
    localparam int IDX_W    = 4;
    localparam int NUM_W    = COORD_W + FRAC_W;
    localparam int DIV_STEPS = NUM_W;

    localparam logic [COORD_W-1:0] ONE_Q16 = 32'h0001_0000;
    localparam logic [COORD_W-1:0] SAT_MAX = 32'h7fff_ffff;
    localparam logic [COORD_W-1:0] SAT_MIN = 32'h8000_0000;

    localparam logic [CFG_W-1:0] CFG_RESET [NUM_REGS] = '{
        64'h0000_0000_0001_0000, 64'h0,
        64'h0001_0000_0000_0000, 64'h0,
        64'h0, 64'h0000_0000_0001_0000,
        64'h0, 64'h0001_0000_0000_0000
    };

endpackage

// File: rtl/homogeneous_point_transform_unit.sv
// Top level of the homogeneous point transform unit: 4x4 matrix product
// followed by a pipelined perspective divide. Depends on hpt_pkg.
//
// Usage: an input word on s_tdata carries x, y, z, w (signed Q16.16). The
// block multiplies it by the 4x4 matrix held in eight 64-bit registers,
// written through cfg_we/cfg_index/cfg_data; the user must write them only
// while the block is idle, which the block itself does not enforce. If the
// transformed w is nonzero, x, y and z are divided by it and w becomes
// 1.0; otherwise the values pass through and m_tuser is set. There are
// one multiply stage, two adder stages, a divide setup stage, 48 restoring
// divider steps (one quotient bit per stage, three lanes side by side)
// and the output register. Throughput is one word per cycle unless the
// receiver stalls; the whole pipeline advances together. When the
// receiver stalls with a result held in the output register, every stage
// holds and s_tready drops; nothing is lost or repeated. Bubbles still
// move forward, so s_tready stays high while the output register is empty.
// Reset clears all valid bits and loads the identity matrix.
module homogeneous_point_transform_unit
    import hpt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [127:0]       s_tdata,   // in_x, in_y, in_z, in_w
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [127:0]       m_tdata,   // out_x, out_y, out_z, out_w
    output logic [0:0]         m_tuser,   // at_infinity
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    logic [CFG_W-1:0] cfg_reg [NUM_REGS];
    logic en;

    logic               v1_reg, v2_reg, v3_reg, vo_reg;
    logic               vd_reg [DIV_STEPS+1];
    logic signed [63:0] prod_reg [4][4];
    logic signed [64:0] pair_reg [4][2];
    logic signed [31:0] t_reg [4];
    logic [NUM_W-1:0]   dv_reg  [DIV_STEPS+1][3];
    logic [31:0]        rem_reg [DIV_STEPS+1][3];
    logic [31:0]        d_reg   [DIV_STEPS+1];
    logic               neg_reg [DIV_STEPS+1][3];
    logic               wz_reg  [DIV_STEPS+1];
    logic [31:0]        res_reg [3];
    logic               inf_reg;

    function automatic logic signed [31:0] sat_row(input logic signed [65:0] s);
        logic signed [49:0] f;
        f = 50'(s >>> FRAC_W);
        if (f > 50'sh0_7fff_ffff)
            return SAT_MAX;
        else if (f < -50'sh0_8000_0000)
            return SAT_MIN;
        else
            return f[31:0];
    endfunction

    assign en       = !vo_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = vo_reg;
    assign m_tdata  = {(inf_reg ? 32'h0 : ONE_Q16), res_reg[2], res_reg[1], res_reg[0]};
    assign m_tuser  = inf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end
        else if (cfg_we && cfg_index < IDX_W'(NUM_REGS))
        begin
            cfg_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
            for (int k = 0; k <= DIV_STEPS; k++)
            begin
                vd_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v1_reg    <= s_tvalid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            vd_reg[0] <= v3_reg;
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                vd_reg[k] <= vd_reg[k-1];
            end
            vo_reg <= vd_reg[DIV_STEPS];
        end
    end

    // Multiply, pair sums, row sums with floor and saturation.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    prod_reg[r][c] <= $signed(cfg_reg[2*r + c/2][(c%2)*32 +: 32])
                                      * $signed(s_tdata[c*32 +: 32]);
                end
                for (int h = 0; h < 2; h++)
                begin
                    pair_reg[r][h] <= 65'(prod_reg[r][2*h]) + 65'(prod_reg[r][2*h+1]);
                end
            end
            for (int r = 0; r < 4; r++)
            begin
                t_reg[r] <= sat_row(66'(pair_reg[r][0]) + 66'(pair_reg[r][1]));
            end
        end
    end

    // Divide setup: a zero w divides the raw value by one, which passes it through.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            logic              wz;
            logic signed [NUM_W-1:0] num;
            wz = (t_reg[3] == 32'sd0);
            wz_reg[0] <= wz;
            d_reg[0]  <= wz ? 32'd1 : (t_reg[3][31] ? 32'(-t_reg[3]) : t_reg[3]);
            for (int i = 0; i < 3; i++)
            begin
                num = wz ? NUM_W'(t_reg[i]) : {t_reg[i], {FRAC_W{1'b0}}};
                dv_reg[0][i]  <= num[NUM_W-1] ? NUM_W'(-num) : num;
                rem_reg[0][i] <= '0;
                neg_reg[0][i] <= num[NUM_W-1] ^ (!wz && t_reg[3][31]);
            end
        end
    end

    genvar k, j;
    generate
        for (k = 0; k < DIV_STEPS; k++)
        begin : g_div
            for (j = 0; j < 3; j++)
            begin : g_lane
                logic [32:0]      trial;
                logic             ge;
                logic [31:0]      rem_next;
                logic [NUM_W-1:0] dv_next;
                assign trial    = {rem_reg[k][j], dv_reg[k][j][NUM_W-1]};
                assign ge       = trial >= {1'b0, d_reg[k]};
                assign rem_next = ge ? 32'(trial - {1'b0, d_reg[k]}) : trial[31:0];
                assign dv_next  = {dv_reg[k][j][NUM_W-2:0], ge};
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[k+1][j] <= rem_next;
                        dv_reg[k+1][j]  <= dv_next;
                        neg_reg[k+1][j] <= neg_reg[k][j];
                    end
                end
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    d_reg[k+1]  <= d_reg[k];
                    wz_reg[k+1] <= wz_reg[k];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            logic [NUM_W-1:0] q;
            inf_reg <= wz_reg[DIV_STEPS];
            for (int i = 0; i < 3; i++)
            begin
                q = dv_reg[DIV_STEPS][i];
                if (neg_reg[DIV_STEPS][i])
                    res_reg[i] <= (q > NUM_W'(48'h8000_0000)) ? SAT_MIN : 32'(-q);
                else
                    res_reg[i] <= (q > NUM_W'(48'h7fff_ffff)) ? SAT_MAX : q[31:0];
            end
        end
    end

endmodule

// File: rtl/hpt_checker.sv
// Port-level checks for the homogeneous point transform unit, bound to the
// top level. Depends on hpt_pkg.
module hpt_port_checks
    import hpt_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic [0:0]   m_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output word changed");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input not ready while output register empty");

    a_inf_w: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[127:96] == 32'h0)
        else $error("point at infinity with nonzero w");

    a_fin_w: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[127:96] == ONE_Q16)
        else $error("divided point without unit w");

endmodule

bind homogeneous_point_transform_unit hpt_port_checks u_hpt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
